### design/lzd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants for the RGB32 LZ pixel decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int ADDR_W_MAX = 24;

    // Register byte address on the configuration port
    localparam logic [2:0] ADDR_IMG_PIX = 3'd0;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REF_START = 3'd1;
    localparam logic [2:0] ST_OVERRUN   = 3'd2;
    localparam logic [2:0] ST_CROSS_IMG = 3'd3;
    localparam logic [2:0] ST_BYTE_MTCH = 3'd4;
    localparam logic [2:0] ST_BEYOND    = 3'd5;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // One queued operation for the history/output side
    typedef struct packed {
        logic                  copy;     // pixel comes from history
        logic                  wr_en;    // pixel is stored to history
        logic [ADDR_W_MAX-1:0] wr_addr;
        logic [ADDR_W_MAX-1:0] rd_addr;
        logic [23:0]           pix;
        logic                  last;
        logic [2:0]            status;
    } op_t;

endpackage

### design/lz_rgb32_pixel_decompressor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_rgb32_pixel_decompressor_unit
// Decodes the pixel body of one LZ-compressed RGB32 image, one byte or one
// match pull per transaction.
//
// Channel  Dir  Payload
// s_*      in   tdata = data_byte[7:0]; tuser = command (0 byte, 1 pull)
// m_*      out  tdata = blue, green, red; tlast = last_pixel; tuser = status
// p*       in   APB, image_pixels at address 0
//
// One transaction per cycle while s_tready is high. A result travels from
// its transaction through parser, queue, history read and output register.
// Reset clears the parser, queue and error state; history is not cleared.
// Output back-pressure fills the four-entry queue, then drops s_tready.
// ----------------------------------------------------------------------------
module lz_rgb32_pixel_decompressor_unit #(
    parameter int HISTORY_PIXELS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // blue[7:0], green[15:8], red[23:16]
    output logic        m_tlast,   // last_pixel
    output logic [2:0]  m_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [24:0]  img_pix_reg;
    logic         push;
    lzd_pkg::op_t push_op;
    logic         q_full;
    logic         pop;
    logic         q_valid;
    lzd_pkg::op_t q_op;

    assign pready = 1'b1;
    assign prdata = (paddr == lzd_pkg::ADDR_IMG_PIX) ? {7'd0, img_pix_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_pix_reg <= 25'd1;
        end
        else if (psel && penable && pwrite && paddr == lzd_pkg::ADDR_IMG_PIX)
        begin
            img_pix_reg <= pwdata[24:0];
        end
    end

    lzd_front #(
        .HISTORY_PIXELS(HISTORY_PIXELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .cmd          (s_tuser),
        .data_byte    (s_tdata),
        .image_pixels (img_pix_reg),
        .q_full       (q_full),
        .push         (push),
        .push_op      (push_op)
    );

    lzd_opq u_opq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    lzd_back #(
        .HISTORY_PIXELS(HISTORY_PIXELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_op       (q_op),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pix    (m_tdata),
        .out_last   (m_tlast),
        .out_status (m_tuser)
    );

endmodule

### design/lzd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_front
// Stream parser: decodes control, length, offset and distance bytes, builds
// literal pixels and issues one operation per pixel or error.
// ----------------------------------------------------------------------------
module lzd_front #(
    parameter int HISTORY_PIXELS = 65536
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          cmd,
    input  logic [7:0]    data_byte,
    input  logic [24:0]   image_pixels,
    input  logic          q_full,
    output logic          push,
    output lzd_pkg::op_t  push_op
);

    localparam int AW = $clog2(HISTORY_PIXELS);
    localparam logic [AW:0] H_EXT = (AW+1)'(HISTORY_PIXELS);
    localparam logic [AW-1:0] H_TOP = AW'(HISTORY_PIXELS - 1);

    localparam logic [3:0] PH_CTRL    = 4'd0;
    localparam logic [3:0] PH_LEN     = 4'd1;
    localparam logic [3:0] PH_OFS1    = 4'd2;
    localparam logic [3:0] PH_OFS2    = 4'd3;
    localparam logic [3:0] PH_DIST    = 4'd4;
    localparam logic [3:0] PH_DIST_VL = 4'd5;
    localparam logic [3:0] PH_VLONG   = 4'd6;
    localparam logic [3:0] PH_LIT     = 4'd7;
    localparam logic [3:0] PH_MATCH   = 4'd8;
    localparam logic [3:0] PH_ERR     = 4'd9;

    logic [3:0]    phase_reg, phase_next;
    logic [24:0]   pcount_reg, pcount_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [24:0]   mlen_reg, mlen_next;
    logic [24:0]   pofs_reg, pofs_next;
    logic          long_reg, long_next;
    logic [1:0]    dleft_reg, dleft_next;
    logic          dnz_reg, dnz_next;
    logic [5:0]    lit_reg, lit_next;
    logic [1:0]    bip_reg, bip_next;
    logic [15:0]   part_reg, part_next;
    logic [2:0]    err_reg, err_next;

    logic          accept;
    logic          emit_pix;
    logic          set_err;
    logic [2:0]    err_code;
    logic          do_fin;
    logic [24:0]   pc1;
    logic          is_last;
    logic [25:0]   ofs;
    logic [25:0]   lit_sum;
    logic [25:0]   run_end;
    logic [25:0]   len_sum;
    logic [AW:0]   rd_diff;
    logic [AW:0]   rd_full;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign pc1      = pcount_reg + 25'd1;
    assign is_last  = (pc1 == image_pixels);
    assign lit_sum  = {1'b0, pcount_reg} + {18'd0, data_byte} + 26'd1;
    assign run_end  = {1'b0, pcount_reg} + {1'b0, mlen_reg};
    assign len_sum  = {1'b0, mlen_reg} + {18'd0, data_byte};

    always_comb
    begin
        phase_next = phase_reg;
        pcount_next = pcount_reg;
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        mlen_next = mlen_reg;
        pofs_next = pofs_reg;
        long_next = long_reg;
        dleft_next = dleft_reg;
        dnz_next = dnz_reg;
        lit_next = lit_reg;
        bip_next = bip_reg;
        part_next = part_reg;
        err_next = err_reg;
        emit_pix = 1'b0;
        set_err = 1'b0;
        err_code = lzd_pkg::ST_OK;
        do_fin = 1'b0;
        push = 1'b0;
        push_op = '0;
        ofs = '0;
        rd_diff = '0;
        rd_full = '0;

        if (accept)
        begin
            if (phase_reg == PH_ERR)
            begin
                set_err = 1'b1;
                err_code = err_reg;
            end
            else if (cmd == lzd_pkg::CMD_PULL)
            begin
                if (phase_reg == PH_MATCH)
                begin
                    emit_pix = 1'b1;
                    push_op.copy = 1'b1;
                    push_op.rd_addr = lzd_pkg::ADDR_W_MAX'(rptr_reg);
                    rptr_next = (rptr_reg == H_TOP) ? '0 : rptr_reg + AW'(1);
                    mlen_next = mlen_reg - 25'd1;
                    if (mlen_next == 25'd0)
                    begin
                        phase_next = PH_CTRL;
                    end
                end
            end
            else
            begin
                unique case (phase_reg) inside
                    PH_CTRL:
                    begin
                        if (data_byte < 8'd32)
                        begin
                            if (lit_sum > {1'b0, image_pixels})
                            begin
                                set_err = 1'b1;
                                err_code = lzd_pkg::ST_OVERRUN;
                            end
                            else
                            begin
                                lit_next = 6'(data_byte) + 6'd1;
                                bip_next = 2'd0;
                                phase_next = PH_LIT;
                            end
                        end
                        else
                        begin
                            mlen_next = {22'd0, data_byte[7:5]};
                            long_next = data_byte[4];
                            pofs_next = {21'd0, data_byte[3:0]};
                            dnz_next = 1'b0;
                            dleft_next = 2'd0;
                            phase_next = (data_byte[7:5] == 3'd7) ? PH_LEN : PH_OFS1;
                        end
                    end
                    PH_LEN:
                    begin
                        mlen_next = len_sum[25] ? 25'h1FFFFFF : len_sum[24:0];
                        if (data_byte != 8'hFF)
                        begin
                            phase_next = PH_OFS1;
                        end
                    end
                    PH_OFS1:
                    begin
                        pofs_next = pofs_reg + {13'd0, data_byte, 4'd0};
                        phase_next = PH_OFS2;
                    end
                    PH_OFS2:
                    begin
                        dleft_next = data_byte[7:6];
                        if (!long_reg)
                        begin
                            dnz_next = (data_byte[5:0] != 6'd0);
                            phase_next = PH_DIST;
                        end
                        else
                        begin
                            pofs_next = pofs_reg + {8'd0, data_byte[4:0], 12'd0};
                            phase_next = data_byte[5] ? PH_DIST_VL : PH_DIST;
                        end
                        if (dleft_next == 2'd0)
                        begin
                            if (phase_next == PH_DIST_VL)
                            begin
                                phase_next = PH_VLONG;
                            end
                            else
                            begin
                                do_fin = 1'b1;
                            end
                        end
                    end
                    PH_DIST, PH_DIST_VL:
                    begin
                        if (data_byte != 8'd0)
                        begin
                            dnz_next = 1'b1;
                        end
                        dleft_next = dleft_reg - 2'd1;
                        if (dleft_next == 2'd0)
                        begin
                            if (phase_reg == PH_DIST_VL)
                            begin
                                phase_next = PH_VLONG;
                            end
                            else
                            begin
                                do_fin = 1'b1;
                            end
                        end
                    end
                    PH_VLONG:
                    begin
                        pofs_next = pofs_reg + {data_byte, 17'd0};
                        do_fin = 1'b1;
                    end
                    PH_LIT:
                    begin
                        if (bip_reg == 2'd0)
                        begin
                            part_next = {part_reg[15:8], part_reg[7:0] | data_byte};
                            bip_next = 2'd1;
                        end
                        else if (bip_reg == 2'd1)
                        begin
                            part_next = {part_reg[15:8] | data_byte, part_reg[7:0]};
                            bip_next = 2'd2;
                        end
                        else
                        begin
                            emit_pix = 1'b1;
                            push_op.pix = {data_byte, part_reg};
                            part_next = '0;
                            bip_next = 2'd0;
                            lit_next = lit_reg - 6'd1;
                            if (lit_next == 6'd0)
                            begin
                                phase_next = PH_CTRL;
                            end
                        end
                    end
                    PH_MATCH:
                    begin
                        set_err = 1'b1;
                        err_code = lzd_pkg::ST_BYTE_MTCH;
                    end
                    default:
                    begin
                        set_err = 1'b1;
                        err_code = lzd_pkg::ST_OVERRUN;
                    end
                endcase
            end

            // Close a match header: checks run cross-image, start, overrun, history
            if (do_fin)
            begin
                ofs = {1'b0, pofs_next} + 26'd1;
                if (dnz_next)
                begin
                    set_err = 1'b1;
                    err_code = lzd_pkg::ST_CROSS_IMG;
                end
                else if (ofs > {1'b0, pcount_reg})
                begin
                    set_err = 1'b1;
                    err_code = lzd_pkg::ST_REF_START;
                end
                else if (run_end > {1'b0, image_pixels})
                begin
                    set_err = 1'b1;
                    err_code = lzd_pkg::ST_OVERRUN;
                end
                else if (ofs > 26'(HISTORY_PIXELS))
                begin
                    set_err = 1'b1;
                    err_code = lzd_pkg::ST_BEYOND;
                end
                else
                begin
                    rd_diff = {1'b0, wptr_reg} - ofs[AW:0];
                    rd_full = rd_diff[AW] ? rd_diff + H_EXT : rd_diff;
                    rptr_next = rd_full[AW-1:0];
                    phase_next = PH_MATCH;
                end
            end

            if (emit_pix)
            begin
                push = 1'b1;
                push_op.wr_en = 1'b1;
                push_op.wr_addr = lzd_pkg::ADDR_W_MAX'(wptr_reg);
                push_op.last = is_last;
                push_op.status = lzd_pkg::ST_OK;
                pcount_next = is_last ? '0 : pc1;
                wptr_next = (is_last || wptr_reg == H_TOP) ? '0 : wptr_reg + AW'(1);
            end

            if (set_err)
            begin
                push = 1'b1;
                push_op = '0;
                push_op.status = err_code;
                phase_next = PH_ERR;
                err_next = err_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CTRL;
            pcount_reg <= '0;
            wptr_reg <= '0;
            rptr_reg <= '0;
            mlen_reg <= '0;
            pofs_reg <= '0;
            long_reg <= 1'b0;
            dleft_reg <= '0;
            dnz_reg <= 1'b0;
            lit_reg <= '0;
            bip_reg <= '0;
            part_reg <= '0;
            err_reg <= lzd_pkg::ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            pcount_reg <= pcount_next;
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            mlen_reg <= mlen_next;
            pofs_reg <= pofs_next;
            long_reg <= long_next;
            dleft_reg <= dleft_next;
            dnz_reg <= dnz_next;
            lit_reg <= lit_next;
            bip_reg <= bip_next;
            part_reg <= part_next;
            err_reg <= err_next;
        end
    end

endmodule

### design/lzd_opq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_opq
// Four-entry operation queue between the parser and the history side.
// ----------------------------------------------------------------------------
module lzd_opq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lzd_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output lzd_pkg::op_t  q_op
);

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    lzd_pkg::op_t  slot_reg [DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW:0]   count_reg, count_next;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_op    = slot_reg[head_reg];

    always_comb
    begin
        head_next = pop ? head_reg + PW'(1) : head_reg;
        tail_next = push ? tail_reg + PW'(1) : tail_reg;
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### design/lzd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_back
// History store and output stage: replays match pixels, records every
// emitted pixel and drives the result register.
// ----------------------------------------------------------------------------
module lzd_back #(
    parameter int HISTORY_PIXELS = 65536
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  lzd_pkg::op_t  q_op,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [23:0]   out_pix,
    output logic          out_last,
    output logic [2:0]    out_status
);

    localparam int AW = $clog2(HISTORY_PIXELS);

    logic [23:0]  hist_mem [HISTORY_PIXELS];
    logic [23:0]  mem_q_reg;
    logic         a_valid_reg;
    lzd_pkg::op_t a_op_reg;
    logic         a_byp_reg;
    logic [23:0]  a_byp_pix_reg;
    logic         out_valid_reg;
    logic [23:0]  out_pix_reg;
    logic         out_last_reg;
    logic [2:0]   out_status_reg;

    logic         b_adv;
    logic         a_wr;
    logic [23:0]  a_pix;

    assign b_adv = !out_valid_reg || out_ready;
    assign pop   = q_valid && (!a_valid_reg || b_adv);
    assign a_wr  = a_valid_reg && b_adv && a_op_reg.wr_en;
    assign a_pix = !a_op_reg.copy ? a_op_reg.pix : (a_byp_reg ? a_byp_pix_reg : mem_q_reg);

    assign out_valid  = out_valid_reg;
    assign out_pix    = out_pix_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

    always_ff @(posedge clk)
    begin
        if (a_wr)
        begin
            hist_mem[a_op_reg.wr_addr[AW-1:0]] <= a_pix;
        end
        if (pop)
        begin
            mem_q_reg <= hist_mem[q_op.rd_addr[AW-1:0]];
        end
    end

    // Forward a pixel being stored in the same cycle as its read
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_op_reg <= q_op;
            a_byp_reg <= a_wr && (a_op_reg.wr_addr[AW-1:0] == q_op.rd_addr[AW-1:0]);
            a_byp_pix_reg <= a_pix;
        end
        if (b_adv && a_valid_reg)
        begin
            out_pix_reg <= a_pix;
            out_last_reg <= a_op_reg.last;
            out_status_reg <= a_op_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (b_adv)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB32 LZ pixel decompressor. A directed table
// covers reset, literals, short and long matches and an idle pull; random
// well-formed images of varied sizes follow, and one sticky error closes the
// run. Pixels are checked against a bit-exact decoder predictor or a typed row's value.
// ----------------------------------------------------------------------------
module tb;

    localparam int HIST      = 65536;
    localparam int MAX_IMAGE = 16777216;
    localparam int MASK25    = 32'h1FF_FFFF;

    typedef enum logic [3:0] {
        P_CTRL, P_LEN, P_OFS1, P_OFS2, P_DIST, P_DIST_VL, P_VLONG, P_LIT, P_MATCH, P_ERR
    } parse_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
        logic [2:0] status;
    } pixel_t;

    typedef struct {
        bit         is_cfg;
        int         cfg_val;
        logic       cmd;
        logic [7:0] dat;
        bit         typed;
        pixel_t     want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lz_rgb32_pixel_decompressor_unit u_top (.*);

    always #5 clk = ~clk;

    // decoder mirror
    parse_t      ph;
    logic [24:0] img_pixels, pix_cnt, m_len, ofs_raw, src;
    logic        long_ofs, dist_nz;
    logic [1:0]  dist_left, byte_idx;
    logic [5:0]  lit_left;
    logic [15:0] partial;
    logic [2:0]  err;
    logic [23:0] history [HIST];

    pixel_t pixel_q[$];
    row_t   rows[$];
    int     fails = 0;
    bit     quiet = 0;
    int     items = 0;

    function automatic pixel_t mk_err(logic [2:0] code);
        pixel_t o;
        err = code;
        ph  = P_ERR;
        o = '0;
        o.status = code;
        return o;
    endfunction

    function automatic pixel_t mk_pix(logic [23:0] p);
        pixel_t o;
        history[pix_cnt % HIST] = p;
        pix_cnt = pix_cnt + 25'd1;
        o.blue   = p[7:0];
        o.green  = p[15:8];
        o.red    = p[23:16];
        o.last   = (pix_cnt == img_pixels);
        o.status = lzd_pkg::ST_OK;
        if (o.last)
            pix_cnt = '0;
        return o;
    endfunction

    function automatic bit close_header(output pixel_t o);
        longint ofs;
        ofs = longint'(ofs_raw) + 1;
        if (dist_nz)
        begin
            o = mk_err(lzd_pkg::ST_CROSS_IMG);
            return 1;
        end
        if (ofs > pix_cnt)
        begin
            o = mk_err(lzd_pkg::ST_REF_START);
            return 1;
        end
        if (longint'(pix_cnt) + m_len > img_pixels)
        begin
            o = mk_err(lzd_pkg::ST_OVERRUN);
            return 1;
        end
        if (ofs > HIST)
        begin
            o = mk_err(lzd_pkg::ST_BEYOND);
            return 1;
        end
        src = pix_cnt - 25'(ofs);
        ph  = P_MATCH;
        return 0;
    endfunction

    function automatic bit after_dist(output pixel_t o);
        if (ph == P_DIST_VL)
        begin
            ph = P_VLONG;
            return 0;
        end
        return close_header(o);
    endfunction

    function automatic bit decode(logic cmd, logic [7:0] b, output pixel_t o);
        longint sum;
        logic [23:0] p;
        o = '0;
        if (ph == P_ERR)
        begin
            o = mk_err(err);
            return 1;
        end
        if (cmd == lzd_pkg::CMD_PULL)
        begin
            if (ph != P_MATCH)
                return 0;
            p = history[src % HIST];
            src = src + 25'd1;
            m_len = m_len - 25'd1;
            if (m_len == 0)
                ph = P_CTRL;
            o = mk_pix(p);
            return 1;
        end
        case (ph) inside
            P_CTRL:
            begin
                if (b < 32)
                begin
                    if (longint'(pix_cnt) + b + 1 > img_pixels)
                    begin
                        o = mk_err(lzd_pkg::ST_OVERRUN);
                        return 1;
                    end
                    lit_left = 6'(b) + 6'd1;
                    byte_idx = 2'd0;
                    ph = P_LIT;
                    return 0;
                end
                m_len     = 25'(b[7:5]);
                long_ofs  = b[4];
                ofs_raw   = 25'(b[3:0]);
                dist_nz   = 1'b0;
                dist_left = 2'd0;
                ph = (m_len == 7) ? P_LEN : P_OFS1;
                return 0;
            end
            P_LEN:
            begin
                sum = longint'(m_len) + b;
                m_len = (sum > MASK25) ? 25'(MASK25) : 25'(sum);
                if (b != 8'd255)
                    ph = P_OFS1;
                return 0;
            end
            P_OFS1:
            begin
                ofs_raw = ofs_raw + (25'(b) << 4);
                ph = P_OFS2;
                return 0;
            end
            P_OFS2:
            begin
                dist_left = b[7:6];
                if (!long_ofs)
                begin
                    dist_nz = (b[5:0] != 0);
                    ph = P_DIST;
                end
                else
                begin
                    ofs_raw = ofs_raw + (25'(b[4:0]) << 12);
                    ph = b[5] ? P_DIST_VL : P_DIST;
                end
                if (dist_left == 0)
                    return after_dist(o);
                return 0;
            end
            P_DIST, P_DIST_VL:
            begin
                if (b != 0)
                    dist_nz = 1'b1;
                dist_left = dist_left - 2'd1;
                if (dist_left == 0)
                    return after_dist(o);
                return 0;
            end
            P_VLONG:
            begin
                ofs_raw = ofs_raw + (25'(b) << 17);
                return close_header(o);
            end
            P_LIT:
            begin
                if (byte_idx < 2)
                begin
                    partial = partial | (16'(b) << (8 * byte_idx));
                    byte_idx = byte_idx + 2'd1;
                    return 0;
                end
                p = {b, partial};
                partial  = '0;
                byte_idx = 2'd0;
                lit_left = lit_left - 6'd1;
                if (lit_left == 0)
                    ph = P_CTRL;
                o = mk_pix(p);
                return 1;
            end
            P_MATCH:
            begin
                o = mk_err(lzd_pkg::ST_BYTE_MTCH);
                return 1;
            end
            default:
            begin
                o = mk_err(lzd_pkg::ST_OVERRUN);
                return 1;
            end
        endcase
    endfunction

    // Leaves s_tvalid high after the transaction so back-to-back items need no toggle.
    task automatic send(logic cmd, logic [7:0] d, bit typed = 0, pixel_t want = '0);
        int gap;
        pixel_t o;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        if (decode(cmd, d, o))
            pixel_q.push_back(typed ? want : o);
        if (!(cmd == lzd_pkg::CMD_PULL && ph != P_MATCH && ph != P_ERR))
            items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_image_pixels(int v);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= lzd_pkg::ADDR_IMG_PIX;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        img_pixels = 25'(v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_row(logic cmd, logic [7:0] d);
        row_t r;
        r = '{is_cfg: 0, cfg_val: 0, cmd: cmd, dat: d, typed: 0, want: '0};
        rows.push_back(r);
    endtask

    task automatic add_typed(logic [7:0] d, logic cmd, logic [23:0] p, logic last);
        row_t r;
        r = '{is_cfg: 0, cfg_val: 0, cmd: cmd, dat: d, typed: 1,
              want: '{p[7:0], p[15:8], p[23:16], last, lzd_pkg::ST_OK}};
        rows.push_back(r);
    endtask

    task automatic add_cfg(int v);
        row_t r;
        r = '{is_cfg: 1, cfg_val: v, cmd: lzd_pkg::CMD_BYTE, dat: 0, typed: 0, want: '0};
        rows.push_back(r);
    endtask

    // One well-formed literal run or match that fits in the current image.
    task automatic send_run();
        int rem, n, len, ofs, raw, dcnt, cap;
        bit lng, vl;
        logic [7:0] b2;
        rem = int'(img_pixels) - int'(pix_cnt);
        if (pix_cnt == 0 || $urandom_range(0, 2) == 0)
        begin
            n = $urandom_range(1, (rem < 32) ? rem : 32);
            send(lzd_pkg::CMD_BYTE, 8'(n - 1));
            repeat (3 * n) send(lzd_pkg::CMD_BYTE, 8'($urandom));
            return;
        end
        cap = ($urandom_range(0, 9) == 0) ? 700 : 20;
        len = $urandom_range(1, (rem < cap) ? rem : cap);
        cap = (int'(pix_cnt) < HIST) ? int'(pix_cnt) : HIST;
        if ($urandom_range(0, 1) == 0 && cap > 16)
            cap = 16;
        ofs = $urandom_range(1, cap);
        raw = ofs - 1;
        lng = (raw >= 4096) || $urandom_range(0, 1);
        vl  = lng && $urandom_range(0, 1);
        dcnt = $urandom_range(0, 3);
        send(lzd_pkg::CMD_BYTE, {3'((len < 7) ? len : 7), lng, 4'(raw)});
        if (len >= 7)
        begin
            n = len - 7;
            while (n >= 255)
            begin
                send(lzd_pkg::CMD_BYTE, 8'd255);
                n -= 255;
            end
            send(lzd_pkg::CMD_BYTE, 8'(n));
        end
        send(lzd_pkg::CMD_BYTE, 8'(raw >> 4));
        b2 = lng ? {2'(dcnt), vl, 5'(raw >> 12)} : {2'(dcnt), 6'd0};
        send(lzd_pkg::CMD_BYTE, b2);
        repeat (dcnt) send(lzd_pkg::CMD_BYTE, 8'd0);
        if (vl)
            send(lzd_pkg::CMD_BYTE, 8'(raw >> 17));
        repeat (len) send(lzd_pkg::CMD_PULL, 8'($urandom));
    endtask

    // result side
    initial
    begin
        int stall;
        pixel_t want;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pixel_q.size() == 0)
            begin
                $display("%0t: unexpected pixel %h last %b status %0d",
                         $time, m_tdata, m_tlast, m_tuser);
                fails++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (m_tdata !== {want.red, want.green, want.blue})
                begin
                    $display("%0t: pixel expected %h actual %h", $time,
                             {want.red, want.green, want.blue}, m_tdata);
                    fails++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                    fails++;
                end
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_tuser);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        int v, k;
        ph = P_CTRL;
        img_pixels = 25'd1;
        {pix_cnt, m_len, ofs_raw, src, long_ofs, dist_nz, dist_left} = '0;
        {byte_idx, lit_left, partial, err} = '0;

        // one-pixel image at the reset size
        add_row(lzd_pkg::CMD_BYTE, 8'h00);
        add_row(lzd_pkg::CMD_BYTE, 8'h00);
        add_row(lzd_pkg::CMD_BYTE, 8'h00);
        add_typed(8'h00, lzd_pkg::CMD_BYTE, 24'h000000, 1'b1);
        add_cfg(100);
        add_row(lzd_pkg::CMD_BYTE, 8'h01);
        add_row(lzd_pkg::CMD_BYTE, 8'hFF);
        add_row(lzd_pkg::CMD_BYTE, 8'hFF);
        add_typed(8'hFF, lzd_pkg::CMD_BYTE, 24'hFFFFFF, 1'b0);
        add_row(lzd_pkg::CMD_BYTE, 8'hA5);
        add_row(lzd_pkg::CMD_BYTE, 8'h5A);
        add_typed(8'h3C, lzd_pkg::CMD_BYTE, 24'h3C5AA5, 1'b0);
        // short match, length one, nearest pixel
        add_row(lzd_pkg::CMD_BYTE, 8'h20);
        add_row(lzd_pkg::CMD_BYTE, 8'h00);
        add_row(lzd_pkg::CMD_BYTE, 8'h00);
        add_typed(8'h00, lzd_pkg::CMD_PULL, 24'h3C5AA5, 1'b0);
        add_row(lzd_pkg::CMD_PULL, 8'hFF);       // no match pending: dropped
        // long match with a distance byte and a very long offset byte
        add_row(lzd_pkg::CMD_BYTE, 8'h51);
        add_row(lzd_pkg::CMD_BYTE, 8'h00);
        add_row(lzd_pkg::CMD_BYTE, 8'h60);
        add_row(lzd_pkg::CMD_BYTE, 8'h00);
        add_row(lzd_pkg::CMD_BYTE, 8'h00);
        add_row(lzd_pkg::CMD_PULL, 8'h00);
        add_row(lzd_pkg::CMD_PULL, 8'h00);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_image_pixels(rows[i].cfg_val);
            else
                send(rows[i].cmd, rows[i].dat, rows[i].typed, rows[i].want);
        end

        // random images; sizes never drop below the pixels already decoded
        for (int p = 0; items < 1900; p++)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if (p == 0)
                v = MAX_IMAGE;
            else if ($urandom_range(0, 5) == 0)
                v = int'(pix_cnt) + int'($urandom_range(300, 3000));
            else
                v = int'(pix_cnt) + int'($urandom_range(1, 300));
            if (v > MAX_IMAGE)
                v = MAX_IMAGE;
            write_image_pixels(v);
            repeat (12)
            begin
                if ($urandom_range(0, 15) == 0)
                    send(lzd_pkg::CMD_PULL, 8'($urandom));
                send_run();
            end
        end

        // close with one error of a random kind, then show it sticks
        quiet = 0;
        write_image_pixels(int'(pix_cnt) + int'($urandom_range(1, 1000)));
        k = $urandom_range(0, 3);
        case (k)
            0:
            begin
                send(lzd_pkg::CMD_BYTE, 8'h20);
                send(lzd_pkg::CMD_BYTE, 8'h00);
                send(lzd_pkg::CMD_BYTE, 8'h01);
            end
            1:
            begin
                send(lzd_pkg::CMD_BYTE, 8'h30);
                send(lzd_pkg::CMD_BYTE, 8'h00);
                send(lzd_pkg::CMD_BYTE, 8'h20);
                send(lzd_pkg::CMD_BYTE, 8'hFF);
            end
            2:
            begin
                send(lzd_pkg::CMD_BYTE, 8'hE0);
                repeat (10) send(lzd_pkg::CMD_BYTE, 8'hFF);
                send(lzd_pkg::CMD_BYTE, 8'h00);
                send(lzd_pkg::CMD_BYTE, 8'h00);
                send(lzd_pkg::CMD_BYTE, 8'h00);
            end
            default:
            begin
                send(lzd_pkg::CMD_BYTE, 8'h20);
                send(lzd_pkg::CMD_BYTE, 8'h00);
                send(lzd_pkg::CMD_BYTE, 8'h00);
                send(lzd_pkg::CMD_BYTE, 8'h7E);
            end
        endcase
        repeat (6) send(1'($urandom), 8'($urandom));

        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("%0t: timeout, %0d pixels outstanding", $time, pixel_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
design/lzd_pkg.sv
design/lzd_front.sv
design/lzd_opq.sv
design/lzd_back.sv
design/lz_rgb32_pixel_decompressor_unit.sv
dv/tb.sv
